// ===== rtl/qei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qei_pkg
// shared types, constants and helper functions for the x4 quadrature
// decoder with debounced switch and paced reporting
// ----------------------------------------------------------------------------
package qei_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CountW = 32;
    localparam int unsigned IvlW   = 16;
    localparam int unsigned McW    = 4;
    localparam int unsigned ModeW  = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [IvlW-1:0] FastReset     = 16'd200;
    localparam logic [IvlW-1:0] SlowReset     = 16'd1000;
    localparam logic [IvlW-1:0] DebounceReset = 16'd25;
    localparam logic [McW-1:0]  ModeCntReset  = 4'd5;
    localparam logic [1:0]      AbReset       = 2'b11;
    localparam logic [McW-1:0]  ModeCntMax    = 4'd8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FAST     = 2'd0,
        CFG_SLOW     = 2'd1,
        CFG_DEBOUNCE = 2'd2,
        CFG_MODE_CNT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SAMPLE  = 1'b0,
        FUNC_SERVICE = 1'b1
    } t_func;

    typedef struct packed {
        logic [IvlW-1:0] fast_ivl;
        logic [IvlW-1:0] slow_ivl;
        logic [IvlW-1:0] debounce;
        logic [McW-1:0]  mode_cnt;
    } t_cfg;

    typedef struct packed {
        logic             func;
        logic             pin_a;
        logic             pin_b;
        logic             pin_sw;
        logic [TimeW-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic                     report_valid;
        logic signed [CountW-1:0] position;
        logic signed [CountW-1:0] delta;
        logic                     adjust_valid;
        logic                     button_event;
        logic                     button_pressed;
        logic                     mode_change;
        logic [ModeW-1:0]         mode_index;
    } t_result;

    // transition step indexed by {prev_ab, cur_ab}: 1 up, 2 down, 0 none
    function automatic logic [1:0] step_code(input logic [3:0] idx);
        logic [1:0] code;
        unique case (idx)
            4'd2, 4'd4, 4'd11, 4'd13: code = 2'd1;
            4'd1, 4'd7, 4'd8,  4'd14: code = 2'd2;
            default:                  code = 2'd0;
        endcase
        return code;
    endfunction

    function automatic logic [McW-1:0] eff_mode_cnt(input logic [McW-1:0] mc);
        logic [McW-1:0] r;
        if (mc == '0) begin
            r = 4'd1;
        end else if (mc > ModeCntMax) begin
            r = ModeCntMax;
        end else begin
            r = mc;
        end
        return r;
    endfunction

    // (v mod c) for v in 1..8, c in 1..8, by bounded subtraction
    function automatic logic [ModeW-1:0] mode_mod(input logic [McW-1:0] v,
                                                 input logic [McW-1:0] c);
        logic [McW-1:0] r;
        r = v;
        for (int k = 0; k < 8; k++) begin
            if (r >= c) begin
                r = r - c;
            end
        end
        return r[ModeW-1:0];
    endfunction

endpackage

// ===== rtl/qei_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qei_core
// decoder state and combinational next-state update: position, pending delta, report
// pacing, switch debounce and mode index
// ----------------------------------------------------------------------------
module qei_core import qei_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [1:0]        r_prev_ab,   n_prev_ab;
    logic [CountW-1:0] r_pos,       n_pos;
    logic [CountW-1:0] r_pend,      n_pend;
    logic [TimeW-1:0]  r_last_rep,  n_last_rep;
    logic              r_sw_lvl,    n_sw_lvl;
    logic [TimeW-1:0]  r_last_sw,   n_last_sw;
    logic [ModeW-1:0]  r_mode,      n_mode;

    logic [1:0]        cur_ab;
    logic [1:0]        code;
    logic [CountW-1:0] step;
    logic [TimeW-1:0]  since_rep;
    logic [TimeW-1:0]  since_sw;
    logic              moving;
    logic              report;
    logic              sw_edge;
    logic              press;

    always_comb begin
        cur_ab    = {i_item.pin_a, i_item.pin_b};
        code      = step_code({r_prev_ab, cur_ab});
        unique case (code)
            2'd1:    step = CountW'(1);
            2'd2:    step = '1;
            default: step = '0;
        endcase
        since_rep = i_item.now_ms - r_last_rep;
        since_sw  = i_item.now_ms - r_last_sw;
        moving    = (r_pend != '0);
        report    = (moving && (since_rep >= TimeW'(i_cfg.fast_ivl)))
                    || (since_rep >= TimeW'(i_cfg.slow_ivl));
        sw_edge   = (i_item.pin_sw != r_sw_lvl) && (since_sw >= TimeW'(i_cfg.debounce));
        press     = sw_edge && !i_item.pin_sw;

        n_prev_ab  = r_prev_ab;
        n_pos      = r_pos;
        n_pend     = r_pend;
        n_last_rep = r_last_rep;
        n_sw_lvl   = r_sw_lvl;
        n_last_sw  = r_last_sw;
        n_mode     = r_mode;

        o_result = '0;

        if (i_item.func == FUNC_SAMPLE) begin
            n_prev_ab = cur_ab;
            n_pos     = r_pos + step;
            n_pend    = r_pend + step;
        end else begin
            n_pend = '0;
            if (report) begin
                n_last_rep = i_item.now_ms;
            end
            if (sw_edge) begin
                n_sw_lvl  = i_item.pin_sw;
                n_last_sw = i_item.now_ms;
            end
            if (press) begin
                n_mode = mode_mod(McW'(r_mode) + McW'(1), eff_mode_cnt(i_cfg.mode_cnt));
            end
            o_result.report_valid   = report;
            o_result.delta          = r_pend;
            o_result.adjust_valid   = moving;
            o_result.button_event   = sw_edge;
            o_result.button_pressed = press;
            o_result.mode_change    = press;
        end
        o_result.position   = n_pos;
        o_result.mode_index = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab  <= AbReset;
            r_pos      <= '0;
            r_pend     <= '0;
            r_last_rep <= '0;
            r_sw_lvl   <= 1'b1;
            r_last_sw  <= '0;
            r_mode     <= '0;
        end else if (i_fire) begin
            r_prev_ab  <= n_prev_ab;
            r_pos      <= n_pos;
            r_pend     <= n_pend;
            r_last_rep <= n_last_rep;
            r_sw_lvl   <= n_sw_lvl;
            r_last_sw  <= n_last_sw;
            r_mode     <= n_mode;
        end
    end

endmodule

// ===== rtl/quadrature_encoder_with_button_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_top
// x4 quadrature decoder with debounced push switch and paced reporting
//
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------
// input    | i_valid / o_stall       | i_func i_pin_a i_pin_b i_pin_sw i_now_ms
// result   | o_valid / i_stall       | o_report_valid .. o_mode_index
// config   | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
// one item per cycle sustained while the result is not stalled; an item is held in the input register,
// is processed by qei_core and lands in the result register
// synchronous active-low reset restores the register defaults and decoder state
// a stalled result holds the result register; the input register then holds
// and o_stall rises only when both are full
// ----------------------------------------------------------------------------
module quadrature_encoder_with_button_top import qei_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_func,
    input  logic                     i_pin_a,
    input  logic                     i_pin_b,
    input  logic                     i_pin_sw,
    input  logic [TimeW-1:0]         i_now_ms,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_report_valid,
    output logic signed [CountW-1:0] o_position,
    output logic signed [CountW-1:0] o_delta,
    output logic                     o_adjust_valid,
    output logic                     o_button_event,
    output logic                     o_button_pressed,
    output logic                     o_mode_change,
    output logic [ModeW-1:0]         o_mode_index,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [IvlW-1:0]          i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    advance;
    logic    accept;

    assign advance     = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !advance;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_ivl <= FastReset;
            r_cfg.slow_ivl <= SlowReset;
            r_cfg.debounce <= DebounceReset;
            r_cfg.mode_cnt <= ModeCntReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FAST:     r_cfg.fast_ivl <= i_cfg_data;
                CFG_SLOW:     r_cfg.slow_ivl <= i_cfg_data;
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data;
                CFG_MODE_CNT: r_cfg.mode_cnt <= i_cfg_data[McW-1:0];
                default:      r_cfg.mode_cnt <= r_cfg.mode_cnt;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.func   <= i_func;
            r_in.pin_a  <= i_pin_a;
            r_in.pin_b  <= i_pin_b;
            r_in.pin_sw <= i_pin_sw;
            r_in.now_ms <= i_now_ms;
        end
    end

    qei_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_in_valid && advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= core_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_report_valid   = r_out.report_valid;
    assign o_position       = r_out.position;
    assign o_delta          = r_out.delta;
    assign o_adjust_valid   = r_out.adjust_valid;
    assign o_button_event   = r_out.button_event;
    assign o_button_pressed = r_out.button_pressed;
    assign o_mode_change    = r_out.mode_change;
    assign o_mode_index     = r_out.mode_index;

endmodule
